// ===== hw/rtl/variable_message_ring_queue_assert.svh =====
// Assertion macros for the ring queue port checker.
`ifndef VARIABLE_MESSAGE_RING_QUEUE_ASSERT_SVH
`define VARIABLE_MESSAGE_RING_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VMRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VMRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vmrq_pkg.sv =====
// Shared types and constants of the variable message ring queue.
package vmrq_pkg;

  // Default geometry of the ring.
  localparam int unsigned RING_BYTES_DEF    = 4096;
  localparam int unsigned SLOT_ALIGN_DEF    = 64;
  localparam int unsigned HEADER_BYTES_DEF  = 16;
  localparam int unsigned PUBLISH_BATCH_DEF = 32;

  // Fixed field widths.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned PEND_W   = 6;

  // Operation codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_RESERVE_TX  = 3'd0,
    KIND_COMMIT_TX   = 3'd1,
    KIND_ROLLBACK_TX = 3'd2,
    KIND_ACQUIRE_RX  = 3'd3,
    KIND_CONSUME_RX  = 3'd4,
    KIND_FLUSH       = 3'd5
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_NO_ROOM        = 3'd1,
    ST_NO_RESERVATION = 3'd2,
    ST_EMPTY          = 3'd3,
    ST_FATAL          = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_SKIP
  } seq_state_t;

endpackage

// ===== hw/rtl/variable_message_ring_queue.sv =====
// The header is read in EXEC and the result beat is registered as EXEC finishes; an
// acquire that steps over a skip header first passes through SKIP for a second read.
// One operation at a time, held while a result waits; set by the header RAM's registered
// read and the single sequencer that owns all state.
// Reset: all positions, counters and the fatal flag clear; the header RAM is not
// cleared and a slot reads as garbage until a skip or commit writes it.
module variable_message_ring_queue #(
  parameter int unsigned RING_BYTES    = vmrq_pkg::RING_BYTES_DEF,
  parameter int unsigned SLOT_ALIGN    = vmrq_pkg::SLOT_ALIGN_DEF,
  parameter int unsigned HEADER_BYTES  = vmrq_pkg::HEADER_BYTES_DEF,
  parameter int unsigned PUBLISH_BATCH = vmrq_pkg::PUBLISH_BATCH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vmrq_pkg::KIND_W-1:0]   in_kind,
  input  logic [vmrq_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [vmrq_pkg::TAG_W-1:0]    in_type_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vmrq_pkg::STATUS_W-1:0] out_status,
  output logic [vmrq_pkg::OFFSET_W-1:0] out_payload_offset,
  output logic [vmrq_pkg::SIZE_W-1:0]   out_message_size,
  output logic [vmrq_pkg::TAG_W-1:0]    out_message_type,
  output logic [vmrq_pkg::POS_W-1:0]    out_visible_head,
  output logic [vmrq_pkg::POS_W-1:0]    out_visible_tail
);

  // Ring and slot geometry (both sizes are powers of two).
  localparam int unsigned SIZE_W = vmrq_pkg::SIZE_W;
  localparam int unsigned TAG_W  = vmrq_pkg::TAG_W;
  localparam int unsigned POS_W  = vmrq_pkg::POS_W;
  localparam int unsigned PEND_W = vmrq_pkg::PEND_W;
  localparam int unsigned OFF_W  = vmrq_pkg::OFFSET_W;
  localparam int unsigned RW     = $clog2(RING_BYTES);
  localparam int unsigned SW     = $clog2(SLOT_ALIGN);
  localparam int unsigned SLOTS  = RING_BYTES / SLOT_ALIGN;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RSV_W  = RW + 1;
  localparam int unsigned LEN_W  = (RSV_W > SIZE_W + 1) ? RSV_W : SIZE_W + 1;
  localparam int unsigned NEED_W = LEN_W + 1;
  localparam int unsigned CHK_W  = LEN_W + 1;
  localparam int unsigned HDR_W  = 1 + SIZE_W + TAG_W + RSV_W;

  // Sequencer and item registers.
  vmrq_pkg::seq_state_t state_r, state_nxt;
  vmrq_pkg::kind_t      kind_r;
  logic [SIZE_W-1:0]    req_r;
  logic [TAG_W-1:0]     tag_r;
  logic [LEN_W-1:0]     aligned_r;

  // Queue state.
  logic [POS_W-1:0]  write_position_r, write_position_nxt;
  logic [POS_W-1:0]  saved_write_position_r, saved_write_position_nxt;
  logic [RSV_W-1:0]  reserved_tx_r, reserved_tx_nxt;
  logic [POS_W-1:0]  published_head_r, published_head_nxt;
  logic [PEND_W-1:0] pending_tx_r, pending_tx_nxt;
  logic [POS_W-1:0]  read_position_r, read_position_nxt;
  logic [RSV_W-1:0]  reserved_rx_r, reserved_rx_nxt;
  logic [POS_W-1:0]  published_tail_r, published_tail_nxt;
  logic [PEND_W-1:0] pending_rx_r, pending_rx_nxt;
  logic              fatal_r, fatal_nxt;

  // Output register.
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [OFF_W-1:0]  out_offset_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [TAG_W-1:0]  out_type_r;
  logic [POS_W-1:0]  out_head_r;
  logic [POS_W-1:0]  out_tail_r;

  // Result of the finishing step.
  vmrq_pkg::status_t res_status;
  logic [OFF_W-1:0]  res_offset;
  logic [SIZE_W-1:0] res_size;
  logic [TAG_W-1:0]  res_type;

  // Header RAM ports.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [HDR_W-1:0] ram_wdata, ram_rdata;

  logic in_fire, out_free, go_skip, finish;

  assign in_ready = (state_r == vmrq_pkg::SEQ_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Aligned slot size of the incoming request.
  logic [LEN_W-1:0] aligned_in;
  assign aligned_in = (LEN_W'(HEADER_BYTES) + LEN_W'(in_request_size) + LEN_W'(SLOT_ALIGN - 1))
                      & ~LEN_W'(SLOT_ALIGN - 1);

  // Producer side room check.
  logic [RW-1:0]     wp_phys;
  logic [RSV_W-1:0]  wp_space;
  logic              wp_wrap, too_big, no_room;
  logic [NEED_W-1:0] need;
  logic [POS_W-1:0]  used;
  assign wp_phys  = write_position_r[RW-1:0];
  assign wp_space = RSV_W'(RING_BYTES) - RSV_W'(wp_phys);
  assign wp_wrap  = LEN_W'(wp_space) < aligned_r;
  assign need     = NEED_W'(aligned_r) + (wp_wrap ? NEED_W'(wp_space) : NEED_W'(0));
  assign used     = write_position_r - published_tail_r;
  assign too_big  = aligned_r > LEN_W'(RING_BYTES);
  assign no_room  = ({1'b0, used} + (POS_W + 1)'(need)) > (POS_W + 1)'(RING_BYTES);

  // Consumer side header fields and checks.
  logic              hdr_skip, corrupt, rx_empty;
  logic [SIZE_W-1:0] hdr_size;
  logic [TAG_W-1:0]  hdr_type;
  logic [RSV_W-1:0]  hdr_rsv;
  logic [RW-1:0]     rp_phys, acq_phys;
  logic [RSV_W-1:0]  rp_space;
  assign hdr_skip = ram_rdata[HDR_W-1];
  assign hdr_size = ram_rdata[HDR_W-2 -: SIZE_W];
  assign hdr_type = ram_rdata[RSV_W +: TAG_W];
  assign hdr_rsv  = ram_rdata[RSV_W-1:0];
  assign corrupt  = hdr_skip
                 || (CHK_W'(hdr_rsv) > CHK_W'(RING_BYTES))
                 || (CHK_W'(hdr_rsv) < CHK_W'(HEADER_BYTES))
                 || ((CHK_W'(hdr_size) + CHK_W'(HEADER_BYTES)) > CHK_W'(hdr_rsv));
  assign rp_phys  = read_position_r[RW-1:0];
  assign rp_space = RSV_W'(RING_BYTES) - RSV_W'(rp_phys);
  assign acq_phys = (state_r == vmrq_pkg::SEQ_SKIP) ? '0 : rp_phys;
  assign rx_empty = (published_head_r == read_position_r);

  // An acquire that lands on a skip header takes a second header read.
  assign go_skip = (state_r == vmrq_pkg::SEQ_EXEC) && !fatal_r
                && (kind_r == vmrq_pkg::KIND_ACQUIRE_RX) && !rx_empty && hdr_skip;
  assign finish  = out_free && ((state_r == vmrq_pkg::SEQ_SKIP)
                || ((state_r == vmrq_pkg::SEQ_EXEC) && !go_skip));

  // Commit counters with batch publish.
  logic [PEND_W-1:0] pend_tx_inc, pend_rx_inc;
  logic [POS_W-1:0]  wp_commit, rp_commit;
  assign pend_tx_inc = pending_tx_r + PEND_W'(1);
  assign pend_rx_inc = pending_rx_r + PEND_W'(1);
  assign wp_commit   = write_position_r + POS_W'(reserved_tx_r);
  assign rp_commit   = read_position_r + POS_W'(reserved_rx_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vmrq_pkg::SEQ_IDLE: begin
        if (in_fire) begin
          state_nxt = vmrq_pkg::SEQ_EXEC;
        end
      end
      vmrq_pkg::SEQ_EXEC: begin
        if (go_skip) begin
          state_nxt = vmrq_pkg::SEQ_SKIP;
        end else if (finish) begin
          state_nxt = vmrq_pkg::SEQ_IDLE;
        end
      end
      vmrq_pkg::SEQ_SKIP: begin
        if (finish) begin
          state_nxt = vmrq_pkg::SEQ_IDLE;
        end
      end
      default: state_nxt = vmrq_pkg::SEQ_IDLE;
    endcase
  end

  // Operation datapath, RAM control and result.
  always_comb begin
    write_position_nxt       = write_position_r;
    saved_write_position_nxt = saved_write_position_r;
    reserved_tx_nxt          = reserved_tx_r;
    published_head_nxt       = published_head_r;
    pending_tx_nxt           = pending_tx_r;
    read_position_nxt        = read_position_r;
    reserved_rx_nxt          = reserved_rx_r;
    published_tail_nxt       = published_tail_r;
    pending_rx_nxt           = pending_rx_r;
    fatal_nxt                = fatal_r;
    res_status               = vmrq_pkg::ST_OK;
    res_offset               = '0;
    res_size                 = '0;
    res_type                 = '0;
    ram_we                   = 1'b0;
    ram_waddr                = IDX_W'(wp_phys >> SW);
    ram_wdata                = '0;
    ram_re                   = 1'b0;
    ram_raddr                = IDX_W'(rp_phys >> SW);

    if (state_r == vmrq_pkg::SEQ_IDLE) begin
      ram_re = in_fire;
    end else if (go_skip) begin
      // Step over the skip header and fetch the header at the ring start.
      read_position_nxt = read_position_r + POS_W'(rp_space);
      ram_re            = 1'b1;
      ram_raddr         = '0;
    end else if (finish) begin
      if (fatal_r) begin
        res_status = vmrq_pkg::ST_FATAL;
      end else begin
        case (kind_r)
          vmrq_pkg::KIND_RESERVE_TX: begin
            if (too_big || no_room) begin
              res_status = vmrq_pkg::ST_NO_ROOM;
            end else begin
              if (wp_wrap) begin
                ram_we                   = 1'b1;
                ram_wdata                = {1'b1, {(HDR_W - 1){1'b0}}};
                write_position_nxt       = write_position_r + POS_W'(wp_space);
                saved_write_position_nxt = write_position_r + POS_W'(wp_space);
                res_offset               = OFF_W'(HEADER_BYTES);
              end else begin
                saved_write_position_nxt = write_position_r;
                res_offset               = OFF_W'(RSV_W'(wp_phys) + RSV_W'(HEADER_BYTES));
              end
              reserved_tx_nxt = RSV_W'(aligned_r);
            end
          end
          vmrq_pkg::KIND_COMMIT_TX: begin
            if (reserved_tx_r == '0) begin
              res_status = vmrq_pkg::ST_NO_RESERVATION;
            end else if ((CHK_W'(req_r) + CHK_W'(HEADER_BYTES)) > CHK_W'(reserved_tx_r)) begin
              reserved_tx_nxt = '0;
              res_status      = vmrq_pkg::ST_NO_ROOM;
            end else begin
              ram_we             = 1'b1;
              ram_wdata          = {1'b0, req_r, tag_r, reserved_tx_r};
              write_position_nxt = wp_commit;
              reserved_tx_nxt    = '0;
              if (32'(pend_tx_inc) >= PUBLISH_BATCH) begin
                published_head_nxt = wp_commit;
                pending_tx_nxt     = '0;
              end else begin
                pending_tx_nxt = pend_tx_inc;
              end
            end
          end
          vmrq_pkg::KIND_ROLLBACK_TX: begin
            if (reserved_tx_r == '0) begin
              res_status = vmrq_pkg::ST_NO_RESERVATION;
            end else begin
              write_position_nxt = saved_write_position_r;
              reserved_tx_nxt    = '0;
            end
          end
          vmrq_pkg::KIND_ACQUIRE_RX: begin
            if ((state_r == vmrq_pkg::SEQ_EXEC) && rx_empty) begin
              res_status = vmrq_pkg::ST_EMPTY;
            end else if (corrupt) begin
              fatal_nxt  = 1'b1;
              res_status = vmrq_pkg::ST_FATAL;
            end else begin
              reserved_rx_nxt = hdr_rsv;
              res_offset      = OFF_W'(RSV_W'(acq_phys) + RSV_W'(HEADER_BYTES));
              res_size        = hdr_size;
              res_type        = hdr_type;
            end
          end
          vmrq_pkg::KIND_CONSUME_RX: begin
            read_position_nxt = rp_commit;
            reserved_rx_nxt   = '0;
            if (32'(pend_rx_inc) >= PUBLISH_BATCH) begin
              published_tail_nxt = rp_commit;
              pending_rx_nxt     = '0;
            end else begin
              pending_rx_nxt = pend_rx_inc;
            end
          end
          vmrq_pkg::KIND_FLUSH: begin
            if (pending_tx_r != '0) begin
              published_head_nxt = write_position_r;
              pending_tx_nxt     = '0;
            end
            if (pending_rx_r != '0) begin
              published_tail_nxt = read_position_r;
              pending_rx_nxt     = '0;
            end
          end
          default: begin
            res_status = vmrq_pkg::ST_OK;
          end
        endcase
      end
    end
  end

  // Control state and queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                <= vmrq_pkg::SEQ_IDLE;
      write_position_r       <= '0;
      saved_write_position_r <= '0;
      reserved_tx_r          <= '0;
      published_head_r       <= '0;
      pending_tx_r           <= '0;
      read_position_r        <= '0;
      reserved_rx_r          <= '0;
      published_tail_r       <= '0;
      pending_rx_r           <= '0;
      fatal_r                <= 1'b0;
      out_valid_r            <= 1'b0;
    end else begin
      state_r                <= state_nxt;
      write_position_r       <= write_position_nxt;
      saved_write_position_r <= saved_write_position_nxt;
      reserved_tx_r          <= reserved_tx_nxt;
      published_head_r       <= published_head_nxt;
      pending_tx_r           <= pending_tx_nxt;
      read_position_r        <= read_position_nxt;
      reserved_rx_r          <= reserved_rx_nxt;
      published_tail_r       <= published_tail_nxt;
      pending_rx_r           <= pending_rx_nxt;
      fatal_r                <= fatal_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture and result beat payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= vmrq_pkg::kind_t'(in_kind);
      req_r     <= in_request_size;
      tag_r     <= in_type_tag;
      aligned_r <= aligned_in;
    end
    if (finish) begin
      out_status_r <= res_status;
      out_offset_r <= res_offset;
      out_size_r   <= res_size;
      out_type_r   <= res_type;
      out_head_r   <= published_head_nxt;
      out_tail_r   <= published_tail_nxt;
    end
  end

  // Header store: one entry per slot.
  vmrq_ram #(
    .WIDTH(HDR_W),
    .DEPTH(SLOTS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_offset_r;
  assign out_message_size   = out_size_r;
  assign out_message_type   = out_type_r;
  assign out_visible_head   = out_head_r;
  assign out_visible_tail   = out_tail_r;

endmodule

// ===== hw/rtl/vmrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vmrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/vmrq_checker.sv =====
// Port-level checker for the ring queue and its bind to the top level.
`include "variable_message_ring_queue_assert.svh"

module vmrq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [vmrq_pkg::STATUS_W-1:0] out_status,
  input logic [vmrq_pkg::OFFSET_W-1:0] out_payload_offset,
  input logic [vmrq_pkg::SIZE_W-1:0]   out_message_size,
  input logic [vmrq_pkg::TAG_W-1:0]    out_message_type
);

  // A result beat that is held back keeps its status.
  `VMRQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status), "result beat changed while stalled")

  // Operations run one at a time: no new beat right after one is taken.
  `VMRQ_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while an operation is in flight")

  // Any non-ok status carries an all-zero message description.
  `VMRQ_ASSERT_IMP(a_fail_zero, out_valid && (out_status != vmrq_pkg::ST_OK), (out_payload_offset == '0) && (out_message_size == '0) && (out_message_type == '0), "failed result carries message fields")

endmodule

bind variable_message_ring_queue vmrq_checker u_vmrq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_payload_offset(out_payload_offset),
  .out_message_size  (out_message_size),
  .out_message_type  (out_message_type)
);

// ===== test/ring_queue_checker.sv =====
// Result checker for the variable message ring queue: tracks the ring and compares every beat.
`timescale 1ns / 1ps

module ring_queue_checker
  import vmrq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [SIZE_W-1:0]   in_request_size,
  input  logic [TAG_W-1:0]    in_type_tag,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [OFFSET_W-1:0] out_payload_offset,
  input  logic [SIZE_W-1:0]   out_message_size,
  input  logic [TAG_W-1:0]    out_message_type,
  input  logic [POS_W-1:0]    out_visible_head,
  input  logic [POS_W-1:0]    out_visible_tail,
  output int unsigned         fault_count,
  output int unsigned         awaiting_count
);

  localparam int unsigned RING      = RING_BYTES_DEF;
  localparam int unsigned SLOT      = SLOT_ALIGN_DEF;
  localparam int unsigned HDR       = HEADER_BYTES_DEF;
  localparam int unsigned BATCH     = PUBLISH_BATCH_DEF;
  localparam int unsigned HDR_SLOTS = RING / SLOT;

  // One result beat as the queue should present it.
  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] offset;
    logic [SIZE_W-1:0]   size;
    logic [TAG_W-1:0]    mtype;
    logic [POS_W-1:0]    head;
    logic [POS_W-1:0]    tail;
  } ring_answer_t;

  // Producer side of the ring.
  logic [POS_W-1:0]  wr_pos;
  logic [POS_W-1:0]  wr_saved;
  logic [SIZE_W-1:0] tx_held;
  logic [POS_W-1:0]  pub_head;
  logic [PEND_W-1:0] tx_pending;

  // Consumer side of the ring.
  logic [POS_W-1:0]  rd_pos;
  logic [SIZE_W-1:0] rx_held;
  logic [POS_W-1:0]  pub_tail;
  logic [PEND_W-1:0] rx_pending;
  logic              fatal;

  // One header per slot: skip marker, payload size, type and reserved bytes.
  logic              hdr_skip [HDR_SLOTS];
  logic [SIZE_W-1:0] hdr_size [HDR_SLOTS];
  logic [TAG_W-1:0]  hdr_type [HDR_SLOTS];
  logic [SIZE_W-1:0] hdr_rsv  [HDR_SLOTS];

  ring_answer_t unread_answers[$];
  int unsigned  faults = 0;

  function automatic string show_answer(ring_answer_t a);
    return $sformatf("status %0d offset %0d size %0d type %h head %h tail %h",
                     a.status, a.offset, a.size, a.mtype, a.head, a.tail);
  endfunction

  // Applies one operation to the tracked ring and returns the beat it should produce.
  task automatic apply_ring_op(input logic [KIND_W-1:0] kind,
                               input logic [SIZE_W-1:0] req,
                               input logic [TAG_W-1:0]  tag,
                               output ring_answer_t     ans);
    int unsigned     aligned;
    int unsigned     phys;
    int unsigned     space;
    int unsigned     slot;
    logic            wrap;
    logic [POS_W-1:0] occupied;
    longint unsigned need;
    longint unsigned used;
    ans = '0;
    ans.status = ST_OK;
    if (fatal) begin
      ans.status = ST_FATAL;
    end else begin
      case (kind)
        KIND_RESERVE_TX: begin
          aligned = (HDR + req + SLOT - 1) / SLOT * SLOT;
          if (aligned > RING) begin
            ans.status = ST_NO_ROOM;
          end else begin
            phys = wr_pos & (RING - 1);
            space = RING - phys;
            wrap = space < aligned;
            need = aligned + (wrap ? space : 0);
            occupied = wr_pos - pub_tail;
            used = occupied;
            if (used + need > RING) begin
              ans.status = ST_NO_ROOM;
            end else begin
              // The slot does not fit before the end: mark the rest as skipped.
              if (wrap) begin
                slot = phys / SLOT;
                hdr_skip[slot] = 1'b1;
                hdr_size[slot] = '0;
                hdr_type[slot] = '0;
                hdr_rsv[slot] = '0;
                wr_pos = wr_pos + space;
                phys = 0;
              end
              wr_saved = wr_pos;
              tx_held = SIZE_W'(aligned);
              ans.offset = OFFSET_W'(phys + HDR);
            end
          end
        end
        KIND_COMMIT_TX: begin
          if (tx_held == 0) begin
            ans.status = ST_NO_RESERVATION;
          end else if (req > tx_held - HDR) begin
            tx_held = '0;
            ans.status = ST_NO_ROOM;
          end else begin
            slot = (wr_pos & (RING - 1)) / SLOT;
            hdr_skip[slot] = 1'b0;
            hdr_size[slot] = req;
            hdr_type[slot] = tag;
            hdr_rsv[slot] = tx_held;
            wr_pos = wr_pos + tx_held;
            tx_held = '0;
            tx_pending = tx_pending + 1'b1;
            if (tx_pending >= BATCH) begin
              pub_head = wr_pos;
              tx_pending = '0;
            end
          end
        end
        KIND_ROLLBACK_TX: begin
          if (tx_held == 0) begin
            ans.status = ST_NO_RESERVATION;
          end else begin
            wr_pos = wr_saved;
            tx_held = '0;
          end
        end
        KIND_ACQUIRE_RX: begin
          if (pub_head == rd_pos) begin
            ans.status = ST_EMPTY;
          end else begin
            phys = rd_pos & (RING - 1);
            slot = phys / SLOT;
            // A skip marker sends the reader to the start of the ring; the step is kept.
            if (hdr_skip[slot]) begin
              rd_pos = rd_pos + (RING - phys);
              phys = 0;
              slot = 0;
            end
            if (hdr_skip[slot] || hdr_rsv[slot] > RING || hdr_rsv[slot] < HDR ||
                hdr_size[slot] > hdr_rsv[slot] - HDR) begin
              fatal = 1'b1;
              ans.status = ST_FATAL;
            end else begin
              rx_held = hdr_rsv[slot];
              ans.offset = OFFSET_W'(phys + HDR);
              ans.size = hdr_size[slot];
              ans.mtype = hdr_type[slot];
            end
          end
        end
        KIND_CONSUME_RX: begin
          rd_pos = rd_pos + rx_held;
          rx_held = '0;
          rx_pending = rx_pending + 1'b1;
          if (rx_pending >= BATCH) begin
            pub_tail = rd_pos;
            rx_pending = '0;
          end
        end
        KIND_FLUSH: begin
          if (tx_pending > 0) begin
            pub_head = wr_pos;
            tx_pending = '0;
          end
          if (rx_pending > 0) begin
            pub_tail = rd_pos;
            rx_pending = '0;
          end
        end
        default: begin
          // Spare codes leave the ring alone.
        end
      endcase
    end
    ans.head = pub_head;
    ans.tail = pub_tail;
  endtask

  // Compare the result beat first, then record what the new operation beat should give.
  always @(posedge clk) begin
    ring_answer_t want;
    ring_answer_t got;
    if (!rst_n) begin
      wr_pos = '0;
      wr_saved = '0;
      tx_held = '0;
      pub_head = '0;
      tx_pending = '0;
      rd_pos = '0;
      rx_held = '0;
      pub_tail = '0;
      rx_pending = '0;
      fatal = 1'b0;
      for (int s = 0; s < HDR_SLOTS; s++) begin
        hdr_skip[s] = 1'b0;
        hdr_size[s] = '0;
        hdr_type[s] = '0;
        hdr_rsv[s] = '0;
      end
      unread_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{status_t'(out_status), out_payload_offset, out_message_size,
                out_message_type, out_visible_head, out_visible_tail};
        if (unread_answers.size() == 0) begin
          faults++;
          if (faults <= 10) begin
            $display("result beat with nothing awaited: %s", show_answer(got));
          end
        end else begin
          want = unread_answers.pop_front();
          if (got !== want) begin
            faults++;
            if (faults <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", show_answer(want));
              $display("  actual   %s", show_answer(got));
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_ring_op(in_kind, in_request_size, in_type_tag, want);
        unread_answers.push_back(want);
      end
    end
    fault_count <= faults;
    awaiting_count <= unread_answers.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the ring queue test: clock, reset, operation beats, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;
  import vmrq_pkg::*;

  localparam int unsigned TOTAL_OPS = 950;
  localparam int unsigned CALM_FROM = 850;
  localparam int unsigned SLOT      = SLOT_ALIGN_DEF;
  localparam int unsigned HDR       = HEADER_BYTES_DEF;
  localparam int unsigned HDR_SLOTS = RING_BYTES_DEF / SLOT_ALIGN_DEF;
  localparam int unsigned MAX_REQ   = RING_BYTES_DEF;

  // Operation codes the queue does not define.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [SIZE_W-1:0]   in_request_size = '0;
  logic [TAG_W-1:0]    in_type_tag = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [OFFSET_W-1:0] out_payload_offset;
  logic [SIZE_W-1:0]   out_message_size;
  logic [TAG_W-1:0]    out_message_type;
  logic [POS_W-1:0]    out_visible_head;
  logic [POS_W-1:0]    out_visible_tail;

  int unsigned fault_count;
  int unsigned awaiting_count;
  int unsigned sent_ops = 0;
  bit          calm = 1'b0;

  variable_message_ring_queue i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_kind,
    .in_request_size,
    .in_type_tag,
    .out_valid,
    .out_ready,
    .out_status,
    .out_payload_offset,
    .out_message_size,
    .out_message_type,
    .out_visible_head,
    .out_visible_tail
  );

  ring_queue_checker i_checker (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_kind,
    .in_request_size,
    .in_type_tag,
    .out_valid,
    .out_ready,
    .out_status,
    .out_payload_offset,
    .out_message_size,
    .out_message_type,
    .out_visible_head,
    .out_visible_tail,
    .fault_count,
    .awaiting_count
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the queue hangs.
  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

  // Mostly small payloads, now and then anything up to the ring size.
  function automatic int unsigned pick_size();
    if ($urandom_range(0, 11) == 0) begin
      return $urandom_range(0, MAX_REQ);
    end
    return $urandom_range(0, 200);
  endfunction

  // Payload bytes that the aligned slot for a reserve of this size can hold.
  function automatic int unsigned slot_room(int unsigned size);
    return (HDR + size + SLOT - 1) / SLOT * SLOT - HDR;
  endfunction

  function automatic int unsigned cap_size(int unsigned size);
    return (size > MAX_REQ) ? MAX_REQ : size;
  endfunction

  // Presents one operation beat, after an occasional gap, and holds it until taken.
  task automatic put_op(input logic [KIND_W-1:0] kind, input int unsigned size,
                        input logic [TAG_W-1:0] tag);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_request_size <= SIZE_W'(size);
    in_type_tag <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_ops++;
  endtask

  // Holds off the sender until every result beat has come back.
  task automatic drain_queue();
    @(negedge clk) in_valid <= 1'b0;
    while (awaiting_count != 0) @(negedge clk);
  endtask

  // Result side stalls in random bursts, and never once the run is winding down.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        @(negedge clk) out_ready <= 1'b1;
        repeat ($urandom_range(0, 29)) @(negedge clk);
      end
    end
  end

  initial begin
    int unsigned size;
    int unsigned room;
    int unsigned pick;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Empty ring: acquire finds nothing, and a consume without acquire still counts.
    put_op(KIND_ACQUIRE_RX, 0, '0);
    put_op(KIND_CONSUME_RX, 0, '0);
    // Commit and rollback with nothing reserved.
    put_op(KIND_COMMIT_TX, 0, '0);
    put_op(KIND_ROLLBACK_TX, 0, '0);
    // Spare operation codes.
    put_op(KIND_SPARE_LO, MAX_REQ, 32'hFFFF_FFFF);
    put_op(KIND_SPARE_HI, 0, '0);
    // Oversized reserve; a second reserve replaces the first; commit larger than the slot.
    put_op(KIND_RESERVE_TX, MAX_REQ, '0);
    put_op(KIND_RESERVE_TX, MAX_REQ - HDR, '0);
    put_op(KIND_RESERVE_TX, 0, '0);
    put_op(KIND_COMMIT_TX, slot_room(0) + 1, '0);
    // One message that fills the whole ring, published and drained.
    put_op(KIND_RESERVE_TX, MAX_REQ - HDR, '0);
    put_op(KIND_COMMIT_TX, MAX_REQ - HDR, 32'hFFFF_FFFF);
    put_op(KIND_FLUSH, 0, '0);
    put_op(KIND_ACQUIRE_RX, 0, '0);
    put_op(KIND_CONSUME_RX, 0, '0);
    put_op(KIND_FLUSH, 0, '0);
    // Leave a two-slot gap before the end of the ring, tail not yet published.
    put_op(KIND_RESERVE_TX, 3904, $urandom);
    put_op(KIND_COMMIT_TX, 3904, $urandom);
    put_op(KIND_FLUSH, 0, '0);
    put_op(KIND_ACQUIRE_RX, 0, '0);
    put_op(KIND_CONSUME_RX, 0, '0);
    // The wrap plus skipped space does not fit until the tail is published.
    put_op(KIND_RESERVE_TX, 200, '0);
    put_op(KIND_FLUSH, 0, '0);
    // Now it wraps behind a skip marker, and the rollback keeps the wrap.
    put_op(KIND_RESERVE_TX, 200, '0);
    put_op(KIND_ROLLBACK_TX, 0, '0);
    // A small message at the ring start; the acquire steps over the skip marker.
    put_op(KIND_RESERVE_TX, 0, '0);
    put_op(KIND_COMMIT_TX, 0, $urandom);
    put_op(KIND_FLUSH, 0, '0);
    put_op(KIND_ACQUIRE_RX, 0, '0);
    put_op(KIND_CONSUME_RX, 0, '0);
    put_op(KIND_FLUSH, 0, '0);

    // One lap of single-slot messages, so every header slot holds a real header
    // before random traffic can send the reader anywhere.
    for (int i = 0; i < HDR_SLOTS; i++) begin
      put_op(KIND_RESERVE_TX, $urandom_range(0, SLOT - HDR), $urandom);
      put_op(KIND_COMMIT_TX, $urandom_range(0, SLOT - HDR), $urandom);
      put_op(KIND_FLUSH, pick_size(), $urandom);
      put_op(KIND_ACQUIRE_RX, pick_size(), $urandom);
      put_op(KIND_CONSUME_RX, pick_size(), $urandom);
    end
    drain_queue();

    // Random traffic: mostly well-formed producer and consumer sequences, some noise.
    while (sent_ops < TOTAL_OPS) begin
      calm = (sent_ops >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        size = pick_size();
        room = slot_room(size);
        put_op(KIND_RESERVE_TX, size, $urandom);
        if ($urandom_range(0, 9) == 0) begin
          put_op(KIND_COMMIT_TX, cap_size(room + $urandom_range(1, 8)), $urandom);
        end else begin
          put_op(KIND_COMMIT_TX, $urandom_range(0, cap_size(room)), $urandom);
        end
      end else if (pick < 38) begin
        put_op(KIND_RESERVE_TX, pick_size(), $urandom);
        put_op(KIND_ROLLBACK_TX, pick_size(), $urandom);
      end else if (pick < 42) begin
        put_op(KIND_RESERVE_TX, pick_size(), $urandom);
        size = pick_size();
        put_op(KIND_RESERVE_TX, size, $urandom);
        put_op(KIND_COMMIT_TX, $urandom_range(0, cap_size(slot_room(size))), $urandom);
      end else if (pick < 72) begin
        put_op(KIND_ACQUIRE_RX, pick_size(), $urandom);
        put_op(KIND_CONSUME_RX, pick_size(), $urandom);
      end else if (pick < 82) begin
        put_op(KIND_FLUSH, pick_size(), $urandom);
      end else if (pick < 83) begin
        drain_queue();
      end else begin
        put_op(KIND_W'($urandom_range(0, 7)), $urandom_range(0, MAX_REQ), $urandom);
      end
    end

    // Let every result come back, then watch for stray beats before the verdict.
    calm = 1'b1;
    @(negedge clk) in_valid <= 1'b0;
    while (awaiting_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fault_count == 0 && awaiting_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== variable_message_ring_queue.f =====
+incdir+hw/rtl
hw/rtl/vmrq_pkg.sv
hw/rtl/vmrq_ram.sv
hw/rtl/variable_message_ring_queue.sv
hw/rtl/vmrq_checker.sv
test/ring_queue_checker.sv
test/testbench.sv
